### hdl/srv_pkg.sv
// Shared types, constants and arithmetic helpers for the spring reverb core.
package srv_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int AP_DEPTH    = 1024;
  localparam int COMB_DEPTH  = 4096;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int COEF_W    = 26;
  localparam int COEF_FRAC = 24;
  localparam int Z_FRAC    = 4;
  localparam int GAIN_FRAC = 15;
  localparam int Z_W       = SAMPLE_BITS + 8;
  localparam int ACC_W     = Z_W + COEF_FRAC - Z_FRAC + 4;

  localparam int MUL_A_W = COEF_W;
  localparam int MUL_B_W = SAMPLE_BITS + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int AP_LINES = 3;
  localparam int CB_LINES = 2;
  localparam int AP_TOTAL = AP_LINES * AP_DEPTH;
  localparam int CB_TOTAL = CB_LINES * COMB_DEPTH;
  localparam int AP_AW    = $clog2(AP_TOTAL);
  localparam int CB_AW    = $clog2(CB_TOTAL);
  localparam int AP_PW    = $clog2(AP_DEPTH);
  localparam int CB_PW    = $clog2(COMB_DEPTH);
  localparam int AP_NW    = $clog2(AP_DEPTH + 1);
  localparam int CB_NW    = $clog2(COMB_DEPTH + 1);
  localparam int AP_SEL_W = $clog2(AP_LINES);

  localparam int CLR_LEN = (AP_TOTAL > CB_TOTAL) ? AP_TOTAL : CB_TOTAL;
  localparam int CLR_W   = $clog2(CLR_LEN);

  localparam int AP_LEN_W   = 11;
  localparam int CB_LEN_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MUL_B_W-1:0]     wide_sample_t;
  typedef logic signed [Z_W-1:0]         z_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic [AP_LEN_W-1:0]           ap_len_t;
  typedef logic [CB_LEN_W-1:0]           cb_len_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  // register indexes on the configuration port
  localparam cfg_idx_t REG_AP_LEN_A = cfg_idx_t'(0);
  localparam cfg_idx_t REG_AP_LEN_B = cfg_idx_t'(1);
  localparam cfg_idx_t REG_AP_LEN_C = cfg_idx_t'(2);
  localparam cfg_idx_t REG_CB_LEN_A = cfg_idx_t'(3);
  localparam cfg_idx_t REG_CB_LEN_B = cfg_idx_t'(4);

  localparam ap_len_t AP_LEN_A_RST = ap_len_t'(225);
  localparam ap_len_t AP_LEN_B_RST = ap_len_t'(341);
  localparam ap_len_t AP_LEN_C_RST = ap_len_t'(441);
  localparam cb_len_t CB_LEN_A_RST = cb_len_t'(1617);
  localparam cb_len_t CB_LEN_B_RST = cb_len_t'(1991);

  // Q1.15 gains
  localparam coef_t G_ALLPASS = coef_t'(19661);
  localparam coef_t G_DAMP    = coef_t'(13763);
  localparam coef_t G_FB_A    = coef_t'(22938);
  localparam coef_t G_FB_B    = coef_t'(22282);

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } bq_coef_t;

  // Q2.24, 48 kHz
  localparam bq_coef_t HP_COEF = '{b0: coef_t'(16374375), b1: coef_t'(-32748750),
                                   b2: coef_t'(16374375), a1: coef_t'(-32739276),
                                   a2: coef_t'(15981023)};
  localparam bq_coef_t LP_COEF = '{b0: coef_t'(758156), b1: coef_t'(1516312),
                                   b2: coef_t'(758156), a1: coef_t'(-21992550),
                                   a2: coef_t'(8247951)};

  localparam acc_t SMP_HI = acc_t'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam acc_t SMP_LO = ~SMP_HI;
  localparam acc_t Z_HI   = acc_t'((longint'(1) <<< (Z_W - 1)) - 1);
  localparam acc_t Z_LO   = ~Z_HI;

  // round half up, then drop s fraction bits
  function automatic acc_t rnd_shift(input acc_t v, input int s);
    acc_t half;
    half = '0;
    half[s-1] = 1'b1;
    return (v + half) >>> s;
  endfunction

  function automatic sample_t sat_sample(input acc_t v);
    acc_t r;
    if (v > SMP_HI) r = SMP_HI;
    else if (v < SMP_LO) r = SMP_LO;
    else r = v;
    return SAMPLE_BITS'(r);
  endfunction

  function automatic z_t sat_z(input acc_t v);
    acc_t r;
    if (v > Z_HI) r = Z_HI;
    else if (v < Z_LO) r = Z_LO;
    else r = v;
    return Z_W'(r);
  endfunction

  // zero length acts as one, lengths past the store clamp to its depth
  function automatic logic [AP_NW-1:0] ap_eff_len(input ap_len_t len);
    logic [AP_NW-1:0] n;
    if (len == '0) n = AP_NW'(1);
    else if (int'(len) > AP_DEPTH) n = AP_NW'(AP_DEPTH);
    else n = AP_NW'(len);
    return n;
  endfunction

  function automatic logic [CB_NW-1:0] cb_eff_len(input cb_len_t len);
    logic [CB_NW-1:0] n;
    if (len == '0) n = CB_NW'(1);
    else if (int'(len) > COMB_DEPTH) n = CB_NW'(COMB_DEPTH);
    else n = CB_NW'(len);
    return n;
  endfunction

  function automatic logic [AP_PW-1:0] ap_next_ptr(input logic [AP_PW-1:0] p,
                                                   input ap_len_t len);
    logic [AP_NW-1:0] p1;
    p1 = AP_NW'(p) + AP_NW'(1);
    return (p1 >= ap_eff_len(len)) ? '0 : AP_PW'(p1);
  endfunction

  function automatic logic [CB_PW-1:0] cb_next_ptr(input logic [CB_PW-1:0] p,
                                                   input cb_len_t len);
    logic [CB_NW-1:0] p1;
    p1 = CB_NW'(p) + CB_NW'(1);
    return (p1 >= cb_eff_len(len)) ? '0 : CB_PW'(p1);
  endfunction

endpackage

### hdl/srv_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module srv_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/srv_mul.sv
// Shared signed multiplier with a registered product.
module srv_mul (
  input  logic                                clk,
  input  logic signed [srv_pkg::MUL_A_W-1:0]  a,
  input  logic signed [srv_pkg::MUL_B_W-1:0]  b,
  output srv_pkg::prod_t                      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hdl/spring_reverb_allpass_comb_core.sv
// Spring reverb: biquad pair, three allpass lines and two damped combs on shared RAMs.
// Samples are processed one at a time on the single shared multiplier: a new request is
//   taken only in the idle state, after the two biquads, three allpass lines, two combs
//   and the output step of the previous sample; the output step waits while the output
//   register holds a result that is not yet taken.
// Reset: synchronous; clears filter state and pointers, loads default lengths, then
//   sweeps both RAMs to zero with s_tready low (configuration still taken).
module spring_reverb_allpass_comb_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [srv_pkg::TDATA_W-1:0]         s_tdata,   // [23:0] dry_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [srv_pkg::TDATA_W-1:0]         m_tdata,   // [23:0] wet_sample
  input  logic                                cfg_wr_en,
  input  logic [srv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srv_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6,
    ST_AP0, ST_AP1, ST_AP2, ST_AP3,
    ST_CB0, ST_CB1, ST_CB2, ST_CB3, ST_CB4,
    ST_OUT
  } state_t;

  state_t state;
  logic [srv_pkg::CLR_W-1:0] clr_cnt;

  srv_pkg::ap_len_t ap_len [srv_pkg::AP_LINES];
  srv_pkg::cb_len_t cb_len [srv_pkg::CB_LINES];

  // filter and line state
  logic             bq_sel;
  srv_pkg::z_t      hp_z1, hp_z2, lp_z1, lp_z2;
  logic [srv_pkg::AP_SEL_W-1:0] ap_sel;
  logic [srv_pkg::AP_PW-1:0]    ap_ptr [srv_pkg::AP_LINES];
  logic                         cb_sel;
  logic [srv_pkg::CB_PW-1:0]    cb_ptr [srv_pkg::CB_LINES];
  srv_pkg::sample_t             damp [srv_pkg::CB_LINES];

  // datapath
  srv_pkg::sample_t      x, y, b_val, v_val;
  srv_pkg::acc_t         acc, acc2;
  srv_pkg::wide_sample_t diff, osum;
  logic                  cb_cur;
  logic [srv_pkg::AP_AW-1:0] ap_waddr;
  logic [srv_pkg::CB_AW-1:0] cb_waddr;

  // multiplier and memories
  logic signed [srv_pkg::MUL_A_W-1:0] mul_a;
  srv_pkg::wide_sample_t              mul_b;
  srv_pkg::prod_t                     prod;
  srv_pkg::bq_coef_t                  coef;
  srv_pkg::z_t                        z1_cur, z2_cur;

  logic                      ap_we, cb_we;
  logic [srv_pkg::AP_AW-1:0] ap_raddr, ap_wa;
  logic [srv_pkg::CB_AW-1:0] cb_raddr, cb_wa;
  srv_pkg::sample_t          ap_wdata, cb_wdata, ap_rdata, cb_rdata;
  logic                      clr_ap;

  assign s_tready = (state == ST_IDLE);

  assign coef   = bq_sel ? srv_pkg::LP_COEF : srv_pkg::HP_COEF;
  assign z1_cur = bq_sel ? lp_z1 : hp_z1;
  assign z2_cur = bq_sel ? lp_z2 : hp_z2;

  // read address follows the selected line, so data is ready when its turn comes
  assign ap_raddr = srv_pkg::AP_AW'(ap_sel) * srv_pkg::AP_AW'(srv_pkg::AP_DEPTH)
                  + srv_pkg::AP_AW'(ap_ptr[ap_sel]);
  assign cb_raddr = srv_pkg::CB_AW'(cb_sel) * srv_pkg::CB_AW'(srv_pkg::COMB_DEPTH)
                  + srv_pkg::CB_AW'(cb_ptr[cb_sel]);

  assign clr_ap = (state == ST_CLEAR)
               && ({1'b0, clr_cnt} < (srv_pkg::CLR_W + 1)'(srv_pkg::AP_TOTAL));

  always_comb begin
    ap_we    = clr_ap || (state == ST_AP2);
    ap_wa    = (state == ST_CLEAR) ? srv_pkg::AP_AW'(clr_cnt) : ap_waddr;
    ap_wdata = (state == ST_CLEAR) ? '0 : v_val;
    cb_we    = (state == ST_CLEAR) || (state == ST_CB4);
    cb_wa    = (state == ST_CLEAR) ? srv_pkg::CB_AW'(clr_cnt) : cb_waddr;
    cb_wdata = (state == ST_CLEAR) ? '0
             : srv_pkg::sat_sample(srv_pkg::ACC_W'(x)
                 + srv_pkg::rnd_shift(srv_pkg::ACC_W'(prod), srv_pkg::GAIN_FRAC));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_B0:   begin mul_a = coef.b0; mul_b = srv_pkg::MUL_B_W'(x); end
      ST_B1:   begin mul_a = coef.b1; mul_b = srv_pkg::MUL_B_W'(x); end
      ST_B2:   begin mul_a = coef.b2; mul_b = srv_pkg::MUL_B_W'(x); end
      ST_B3:   begin mul_a = coef.a1; mul_b = srv_pkg::MUL_B_W'(y); end
      ST_B4:   begin mul_a = coef.a2; mul_b = srv_pkg::MUL_B_W'(y); end
      ST_AP0:  begin mul_a = srv_pkg::G_ALLPASS; mul_b = srv_pkg::MUL_B_W'(ap_rdata); end
      ST_AP2:  begin mul_a = srv_pkg::G_ALLPASS; mul_b = srv_pkg::MUL_B_W'(v_val); end
      ST_CB1:  begin mul_a = srv_pkg::G_DAMP; mul_b = diff; end
      ST_CB3:  begin
        mul_a = cb_cur ? srv_pkg::G_FB_B : srv_pkg::G_FB_A;
        mul_b = srv_pkg::MUL_B_W'(damp[cb_cur]);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  srv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  srv_ram #(.DEPTH(srv_pkg::AP_TOTAL), .WIDTH(srv_pkg::SAMPLE_BITS)) u_ap_ram (
    .clk   (clk),
    .we    (ap_we),
    .waddr (ap_wa),
    .wdata (ap_wdata),
    .raddr (ap_raddr),
    .rdata (ap_rdata)
  );

  srv_ram #(.DEPTH(srv_pkg::CB_TOTAL), .WIDTH(srv_pkg::SAMPLE_BITS)) u_cb_ram (
    .clk   (clk),
    .we    (cb_we),
    .waddr (cb_wa),
    .wdata (cb_wdata),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      bq_sel   <= 1'b0;
      hp_z1    <= '0;
      hp_z2    <= '0;
      lp_z1    <= '0;
      lp_z2    <= '0;
      ap_sel   <= '0;
      cb_sel   <= 1'b0;
      for (int i = 0; i < srv_pkg::AP_LINES; i++) ap_ptr[i] <= '0;
      for (int i = 0; i < srv_pkg::CB_LINES; i++) begin
        cb_ptr[i] <= '0;
        damp[i]   <= '0;
      end
      ap_len[0] <= srv_pkg::AP_LEN_A_RST;
      ap_len[1] <= srv_pkg::AP_LEN_B_RST;
      ap_len[2] <= srv_pkg::AP_LEN_C_RST;
      cb_len[0] <= srv_pkg::CB_LEN_A_RST;
      cb_len[1] <= srv_pkg::CB_LEN_B_RST;
    end else begin
      // in ST_OUT the output register is reloaded below instead
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          srv_pkg::REG_AP_LEN_A: ap_len[0] <= srv_pkg::AP_LEN_W'(cfg_data);
          srv_pkg::REG_AP_LEN_B: ap_len[1] <= srv_pkg::AP_LEN_W'(cfg_data);
          srv_pkg::REG_AP_LEN_C: ap_len[2] <= srv_pkg::AP_LEN_W'(cfg_data);
          srv_pkg::REG_CB_LEN_A: cb_len[0] <= srv_pkg::CB_LEN_W'(cfg_data);
          srv_pkg::REG_CB_LEN_B: cb_len[1] <= srv_pkg::CB_LEN_W'(cfg_data);
          default: ;
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == srv_pkg::CLR_W'(srv_pkg::CLR_LEN - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (s_tvalid) state <= ST_B0;
        ST_B0:   state <= ST_B1;
        ST_B1:   state <= ST_B2;
        ST_B2:   state <= ST_B3;
        ST_B3:   state <= ST_B4;
        ST_B4:   state <= ST_B5;
        ST_B5: begin
          if (bq_sel) lp_z1 <= srv_pkg::sat_z(srv_pkg::rnd_shift(acc, srv_pkg::COEF_FRAC
                                                                 - srv_pkg::Z_FRAC));
          else        hp_z1 <= srv_pkg::sat_z(srv_pkg::rnd_shift(acc, srv_pkg::COEF_FRAC
                                                                 - srv_pkg::Z_FRAC));
          state <= ST_B6;
        end
        ST_B6: begin
          if (bq_sel) lp_z2 <= srv_pkg::sat_z(srv_pkg::rnd_shift(acc2, srv_pkg::COEF_FRAC
                                                                 - srv_pkg::Z_FRAC));
          else        hp_z2 <= srv_pkg::sat_z(srv_pkg::rnd_shift(acc2, srv_pkg::COEF_FRAC
                                                                 - srv_pkg::Z_FRAC));
          bq_sel <= !bq_sel;
          state  <= bq_sel ? ST_AP0 : ST_B0;
        end
        ST_AP0:  state <= ST_AP1;
        ST_AP1: begin
          // line done with its pointer: move on so the next line's read starts early
          ap_ptr[ap_sel] <= srv_pkg::ap_next_ptr(ap_ptr[ap_sel], ap_len[ap_sel]);
          ap_sel <= (ap_sel == srv_pkg::AP_SEL_W'(srv_pkg::AP_LINES - 1))
                  ? '0 : ap_sel + 1'b1;
          state  <= ST_AP2;
        end
        ST_AP2:  state <= ST_AP3;
        ST_AP3:  state <= (ap_sel == '0) ? ST_CB0 : ST_AP0;
        ST_CB0:  state <= ST_CB1;
        ST_CB1: begin
          cb_ptr[cb_sel] <= srv_pkg::cb_next_ptr(cb_ptr[cb_sel], cb_len[cb_sel]);
          cb_sel <= !cb_sel;
          state  <= ST_CB2;
        end
        ST_CB2: begin
          damp[cb_cur] <= srv_pkg::sat_sample(srv_pkg::ACC_W'(damp[cb_cur])
                       + srv_pkg::rnd_shift(srv_pkg::ACC_W'(prod), srv_pkg::GAIN_FRAC));
          state <= ST_CB3;
        end
        ST_CB3:  state <= ST_CB4;
        ST_CB4:  state <= cb_cur ? ST_OUT : ST_CB0;
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= srv_pkg::TDATA_W'($unsigned(srv_pkg::sat_sample(
                          srv_pkg::rnd_shift(srv_pkg::ACC_W'(osum), 1))));
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Each line entry is read long after its last write, so no forwarding is needed.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (s_tvalid) x <= s_tdata[srv_pkg::SAMPLE_BITS-1:0];
      ST_B1:   acc <= srv_pkg::ACC_W'(prod)
                    + (srv_pkg::ACC_W'(z1_cur) <<< (srv_pkg::COEF_FRAC - srv_pkg::Z_FRAC));
      ST_B2: begin
        y   <= srv_pkg::sat_sample(srv_pkg::rnd_shift(acc, srv_pkg::COEF_FRAC));
        acc <= srv_pkg::ACC_W'(prod)
             + (srv_pkg::ACC_W'(z2_cur) <<< (srv_pkg::COEF_FRAC - srv_pkg::Z_FRAC));
      end
      ST_B3:   acc2 <= srv_pkg::ACC_W'(prod);
      ST_B4:   acc  <= acc - srv_pkg::ACC_W'(prod);
      ST_B5:   acc2 <= acc2 - srv_pkg::ACC_W'(prod);
      ST_B6:   x <= y;
      ST_AP0: begin
        b_val    <= ap_rdata;
        ap_waddr <= ap_raddr;
      end
      ST_AP1:  v_val <= srv_pkg::sat_sample(srv_pkg::ACC_W'(x)
                      + srv_pkg::rnd_shift(srv_pkg::ACC_W'(prod), srv_pkg::GAIN_FRAC));
      ST_AP3:  x <= srv_pkg::sat_sample(srv_pkg::ACC_W'(b_val)
                  - srv_pkg::rnd_shift(srv_pkg::ACC_W'(prod), srv_pkg::GAIN_FRAC));
      ST_CB0: begin
        diff     <= srv_pkg::MUL_B_W'(cb_rdata) - srv_pkg::MUL_B_W'(damp[cb_sel]);
        cb_waddr <= cb_raddr;
        cb_cur   <= cb_sel;
        osum     <= cb_sel ? osum + srv_pkg::MUL_B_W'(cb_rdata)
                           : srv_pkg::MUL_B_W'(cb_rdata);
      end
      default: ;
    endcase
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!ap_we && !cb_we))
    else $error("line RAM written while idle");

  a_ap_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CB0 && $past(state) == ST_AP3) |-> (ap_sel == '0))
    else $error("allpass selector not back on the first line at comb entry");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not loaded into output register");

endmodule

### tb/spring_reverb_allpass_comb_core_test.sv
// Self-checking testbench for the spring reverb core: directed table, then random phases.
`timescale 1ns / 100ps

module spring_reverb_allpass_comb_core_test;

  localparam int QUIET_LIMIT = 40000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RAND_ITEMS  = 600;
  localparam int TAIL_CYCLES = 50;
  localparam int ZS_SHIFT    = srv_pkg::COEF_FRAC - srv_pkg::Z_FRAC;

  localparam srv_pkg::cfg_idx_t REG_SPARE_FIRST = srv_pkg::cfg_idx_t'(5);
  localparam srv_pkg::cfg_idx_t REG_SPARE_LAST  = srv_pkg::cfg_idx_t'(7);

  localparam srv_pkg::sample_t S_MAX = srv_pkg::sample_t'(24'h7FFFFF);
  localparam srv_pkg::sample_t S_MIN = srv_pkg::sample_t'(24'h800000);

  // Q1.15 gains
  localparam longint AP_GAIN   = 19661;
  localparam longint DAMP_GAIN = 13763;
  localparam longint FB_GAIN_A = 22938;
  localparam longint FB_GAIN_B = 22282;

  // Q2.24 biquad taps, 48 kHz
  localparam longint HP_B0 = 16374375;
  localparam longint HP_B1 = -32748750;
  localparam longint HP_B2 = 16374375;
  localparam longint HP_A1 = -32739276;
  localparam longint HP_A2 = 15981023;
  localparam longint LP_B0 = 758156;
  localparam longint LP_B1 = 1516312;
  localparam longint LP_B2 = 758156;
  localparam longint LP_A1 = -21992550;
  localparam longint LP_A2 = 8247951;

  typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    srv_pkg::cfg_idx_t                idx;
    logic [srv_pkg::CFG_DATA_W-1:0]   data;
    srv_pkg::sample_t                 dry;
    bit                               fixed;
    srv_pkg::sample_t                 wet;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [srv_pkg::TDATA_W-1:0]     s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [srv_pkg::TDATA_W-1:0]     m_tdata;
  logic                            cfg_wr_en;
  srv_pkg::cfg_idx_t               cfg_index;
  logic [srv_pkg::CFG_DATA_W-1:0]  cfg_data;

  // typed-in expectation travelling with the request
  bit               s_fixed;
  srv_pkg::sample_t s_fixed_wet;

  bit               no_idle;
  bit               out_hold_req;
  int               fault_count;
  srv_pkg::sample_t wet_expected_q [$];
  row_t             plan [$];

  // predictor state
  longint                        filter_z1 [2];
  longint                        filter_z2 [2];
  srv_pkg::ap_len_t              ap_len_q [srv_pkg::AP_LINES];
  srv_pkg::cb_len_t              cb_len_q [srv_pkg::CB_LINES];
  srv_pkg::sample_t              ap_mem [srv_pkg::AP_LINES][srv_pkg::AP_DEPTH];
  srv_pkg::sample_t              cb_mem [srv_pkg::CB_LINES][srv_pkg::COMB_DEPTH];
  logic [srv_pkg::AP_PW-1:0]     ap_pos [srv_pkg::AP_LINES];
  logic [srv_pkg::CB_PW-1:0]     cb_pos [srv_pkg::CB_LINES];
  srv_pkg::sample_t              damp_lvl [srv_pkg::CB_LINES];

  spring_reverb_allpass_comb_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // transposed direct form II, delay state kept in 1/16 LSB
  function automatic longint biquad_out(bit low_pass, longint x);
    longint b0, b1, b2, a1, a2, y, n1, n2;
    int st;
    if (low_pass) begin
      b0 = LP_B0; b1 = LP_B1; b2 = LP_B2; a1 = LP_A1; a2 = LP_A2;
    end else begin
      b0 = HP_B0; b1 = HP_B1; b2 = HP_B2; a1 = HP_A1; a2 = HP_A2;
    end
    st = low_pass;
    y  = clamp(round_shift(b0 * x + (filter_z1[st] <<< ZS_SHIFT), srv_pkg::COEF_FRAC),
               srv_pkg::SAMPLE_BITS);
    n1 = b1 * x - a1 * y + (filter_z2[st] <<< ZS_SHIFT);
    n2 = b2 * x - a2 * y;
    filter_z1[st] = clamp(round_shift(n1, ZS_SHIFT), srv_pkg::SAMPLE_BITS + 8);
    filter_z2[st] = clamp(round_shift(n2, ZS_SHIFT), srv_pkg::SAMPLE_BITS + 8);
    return y;
  endfunction

  function automatic longint allpass_out(int k, longint x);
    int unsigned n, p;
    longint b, v;
    n = ap_len_q[k];
    if (n == 0) n = 1;
    else if (n > srv_pkg::AP_DEPTH) n = srv_pkg::AP_DEPTH;
    p = ap_pos[k];
    b = ap_mem[k][p];
    v = clamp(x + round_shift(b * AP_GAIN, srv_pkg::GAIN_FRAC), srv_pkg::SAMPLE_BITS);
    ap_mem[k][p] = srv_pkg::sample_t'(v);
    // a line shortened below its pointer still uses this slot once
    ap_pos[k] = (p + 1 >= n) ? '0 : srv_pkg::AP_PW'(p + 1);
    return clamp(b - round_shift(v * AP_GAIN, srv_pkg::GAIN_FRAC), srv_pkg::SAMPLE_BITS);
  endfunction

  function automatic longint comb_out(int k, longint x);
    int unsigned n, p;
    longint o, d, fb;
    n = cb_len_q[k];
    if (n == 0) n = 1;
    else if (n > srv_pkg::COMB_DEPTH) n = srv_pkg::COMB_DEPTH;
    fb = (k == 0) ? FB_GAIN_A : FB_GAIN_B;
    p = cb_pos[k];
    o = cb_mem[k][p];
    d = damp_lvl[k];
    d = clamp(d + round_shift((o - d) * DAMP_GAIN, srv_pkg::GAIN_FRAC), srv_pkg::SAMPLE_BITS);
    damp_lvl[k] = srv_pkg::sample_t'(d);
    cb_mem[k][p] = srv_pkg::sample_t'(clamp(x + round_shift(d * fb, srv_pkg::GAIN_FRAC),
                                            srv_pkg::SAMPLE_BITS));
    cb_pos[k] = (p + 1 >= n) ? '0 : srv_pkg::CB_PW'(p + 1);
    return o;
  endfunction

  function automatic srv_pkg::sample_t reverb_predict(srv_pkg::sample_t dry);
    longint x, oa, ob;
    x = dry;
    x = biquad_out(1'b0, x);
    x = biquad_out(1'b1, x);
    for (int k = 0; k < srv_pkg::AP_LINES; k++) x = allpass_out(k, x);
    oa = comb_out(0, x);
    ob = comb_out(1, x);
    return srv_pkg::sample_t'(clamp(round_shift(oa + ob, 1), srv_pkg::SAMPLE_BITS));
  endfunction

  function automatic row_t cfg_row(srv_pkg::cfg_idx_t idx,
                                   logic [srv_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t smp_row(srv_pkg::sample_t dry, bit fixed, srv_pkg::sample_t wet);
    row_t r;
    r = '0;
    r.kind  = ROW_SAMPLE;
    r.dry   = dry;
    r.fixed = fixed;
    r.wet   = wet;
    return r;
  endfunction

  // lengths biased short so the combs return signal within a phase;
  // bits above the register width are junk that must be dropped
  function automatic logic [srv_pkg::CFG_DATA_W-1:0] pick_len(int depth, int bits);
    int unsigned r, v, top;
    top = (1 << bits) - 1;
    r = $urandom_range(0, 99);
    if (r < 8) v = 0;
    else if (r < 16) v = 1;
    else if (r < 24) v = depth;
    else if (r < 32) v = top;
    else if (r < 40) v = $urandom_range(depth + 1, top);
    else if (r < 75) v = $urandom_range(2, 40);
    else v = $urandom_range(0, top);
    return srv_pkg::CFG_DATA_W'(v | ($urandom << bits));
  endfunction

  task automatic send_sample(srv_pkg::sample_t dry, bit fixed, srv_pkg::sample_t wet);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= dry;
    s_fixed     <= fixed;
    s_fixed_wet <= wet;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // block idle once every pending result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (wet_expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(srv_pkg::cfg_idx_t idx, logic [srv_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // predictor follows register writes and requests; results checked in order
  always @(posedge clk) begin : scoreboard
    srv_pkg::sample_t got;
    srv_pkg::sample_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = srv_pkg::sample_t'(m_tdata);
        if (wet_expected_q.size() == 0) begin
          if (fault_count < 10) $display("unexpected wet_sample %0d, nothing pending", got);
          fault_count++;
        end else begin
          want = wet_expected_q.pop_front();
          if (got !== want) begin
            if (fault_count < 10)
              $display("wet_sample mismatch: expected %0d, got %0d", want, got);
            fault_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          srv_pkg::REG_AP_LEN_A: ap_len_q[0] = srv_pkg::ap_len_t'(cfg_data);
          srv_pkg::REG_AP_LEN_B: ap_len_q[1] = srv_pkg::ap_len_t'(cfg_data);
          srv_pkg::REG_AP_LEN_C: ap_len_q[2] = srv_pkg::ap_len_t'(cfg_data);
          srv_pkg::REG_CB_LEN_A: cb_len_q[0] = srv_pkg::cb_len_t'(cfg_data);
          srv_pkg::REG_CB_LEN_B: cb_len_q[1] = srv_pkg::cb_len_t'(cfg_data);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = reverb_predict(srv_pkg::sample_t'(s_tdata));
        wet_expected_q.push_back(s_fixed ? s_fixed_wet : want);
      end
    end
  end

  initial begin : receiver
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold_req = 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("spring_reverb_allpass_comb_core test failed");
    $finish;
  end

  initial begin : stimulus
    int rand_sent;
    int phase;
    int n;
    int style;
    int r;
    int small_v;
    srv_pkg::sample_t dry;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_fixed      = 1'b0;
    s_fixed_wet  = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = srv_pkg::REG_AP_LEN_A;
    cfg_data     = '0;
    no_idle      = 1'b0;
    out_hold_req = 1'b0;
    fault_count  = 0;

    for (int k = 0; k < 2; k++) begin
      filter_z1[k] = 0;
      filter_z2[k] = 0;
    end
    for (int k = 0; k < srv_pkg::AP_LINES; k++) begin
      ap_pos[k] = '0;
      for (int i = 0; i < srv_pkg::AP_DEPTH; i++) ap_mem[k][i] = '0;
    end
    for (int k = 0; k < srv_pkg::CB_LINES; k++) begin
      cb_pos[k]   = '0;
      damp_lvl[k] = '0;
      for (int i = 0; i < srv_pkg::COMB_DEPTH; i++) cb_mem[k][i] = '0;
    end
    ap_len_q[0] = srv_pkg::AP_LEN_A_RST;
    ap_len_q[1] = srv_pkg::AP_LEN_B_RST;
    ap_len_q[2] = srv_pkg::AP_LEN_C_RST;
    cb_len_q[0] = srv_pkg::CB_LEN_A_RST;
    cb_len_q[1] = srv_pkg::CB_LEN_B_RST;

    // combs at reset length return their cleared contents for a long while
    plan.push_back(smp_row(S_MAX, 1'b1, '0));
    plan.push_back(smp_row(S_MIN, 1'b1, '0));
    plan.push_back(smp_row('0, 1'b1, '0));
    plan.push_back(smp_row(srv_pkg::sample_t'(-1), 1'b1, '0));
    plan.push_back(smp_row(srv_pkg::sample_t'(1), 1'b1, '0));
    // zero length acts as one; short lengths of one and two beside it
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_A, '0));
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_B, srv_pkg::CFG_DATA_W'(1)));
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_C, srv_pkg::CFG_DATA_W'(2)));
    plan.push_back(cfg_row(srv_pkg::REG_CB_LEN_A, '0));
    plan.push_back(cfg_row(srv_pkg::REG_CB_LEN_B, srv_pkg::CFG_DATA_W'(1)));
    repeat (3) plan.push_back(smp_row(S_MAX, 1'b0, '0));
    repeat (3) plan.push_back(smp_row(S_MIN, 1'b0, '0));
    plan.push_back(smp_row('0, 1'b0, '0));
    // lengths at and past the store depth, and writes to unused indexes
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_A, srv_pkg::CFG_DATA_W'(2047)));
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_B, srv_pkg::CFG_DATA_W'(srv_pkg::AP_DEPTH)));
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_C,
                           srv_pkg::CFG_DATA_W'(srv_pkg::AP_DEPTH + 1)));
    plan.push_back(cfg_row(srv_pkg::REG_CB_LEN_A, srv_pkg::CFG_DATA_W'(8191)));
    plan.push_back(cfg_row(srv_pkg::REG_CB_LEN_B,
                           srv_pkg::CFG_DATA_W'(srv_pkg::COMB_DEPTH)));
    plan.push_back(cfg_row(REG_SPARE_FIRST, srv_pkg::CFG_DATA_W'(3)));
    plan.push_back(cfg_row(REG_SPARE_LAST, srv_pkg::CFG_DATA_W'(8191)));
    plan.push_back(smp_row(srv_pkg::sample_t'(24'h555555), 1'b0, '0));
    plan.push_back(smp_row(srv_pkg::sample_t'(24'hAAAAAA), 1'b0, '0));
    plan.push_back(smp_row(S_MAX, 1'b0, '0));
    plan.push_back(smp_row(S_MIN, 1'b0, '0));
    plan.push_back(smp_row(srv_pkg::sample_t'(24'h123456), 1'b0, '0));
    plan.push_back(smp_row('0, 1'b0, '0));
    // pointers now sit past these new lengths
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_A, srv_pkg::CFG_DATA_W'(1)));
    plan.push_back(cfg_row(srv_pkg::REG_AP_LEN_C, srv_pkg::CFG_DATA_W'(3)));
    plan.push_back(cfg_row(srv_pkg::REG_CB_LEN_A, srv_pkg::CFG_DATA_W'(2)));
    plan.push_back(cfg_row(srv_pkg::REG_CB_LEN_B, srv_pkg::CFG_DATA_W'(5)));
    plan.push_back(smp_row(S_MAX, 1'b0, '0));
    plan.push_back(smp_row(S_MIN, 1'b0, '0));
    plan.push_back(smp_row(srv_pkg::sample_t'(-1), 1'b0, '0));
    plan.push_back(smp_row(srv_pkg::sample_t'(1), 1'b0, '0));
    plan.push_back(smp_row(srv_pkg::sample_t'(24'h400000), 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].dry, plan[i].fixed, plan[i].wet);
      end
    end

    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RAND_ITEMS) begin
      settle();
      if ($urandom_range(0, 99) < 60)
        write_reg(srv_pkg::REG_AP_LEN_A, pick_len(srv_pkg::AP_DEPTH, srv_pkg::AP_LEN_W));
      if ($urandom_range(0, 99) < 60)
        write_reg(srv_pkg::REG_AP_LEN_B, pick_len(srv_pkg::AP_DEPTH, srv_pkg::AP_LEN_W));
      if ($urandom_range(0, 99) < 60)
        write_reg(srv_pkg::REG_AP_LEN_C, pick_len(srv_pkg::AP_DEPTH, srv_pkg::AP_LEN_W));
      if ($urandom_range(0, 99) < 60)
        write_reg(srv_pkg::REG_CB_LEN_A, pick_len(srv_pkg::COMB_DEPTH, srv_pkg::CB_LEN_W));
      if ($urandom_range(0, 99) < 60)
        write_reg(srv_pkg::REG_CB_LEN_B, pick_len(srv_pkg::COMB_DEPTH, srv_pkg::CB_LEN_W));
      if ($urandom_range(0, 9) == 0)
        write_reg(srv_pkg::cfg_idx_t'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  srv_pkg::CFG_DATA_W'($urandom));
      no_idle = (phase == 2);
      if (phase == 4) out_hold_req = 1'b1;
      n     = no_idle ? 120 : $urandom_range(20, 60);
      style = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (style == 0) begin
          // full-scale square wave drives the saturation paths
          dry = ((i / 8) % 2) ? S_MAX : S_MIN;
        end else if (r < 12) begin
          case ($urandom_range(0, 3))
            0: dry = S_MAX;
            1: dry = S_MIN;
            2: dry = '0;
            default: dry = srv_pkg::sample_t'(-1);
          endcase
        end else if (r < 40) begin
          small_v = $urandom_range(0, 8191);
          dry = srv_pkg::sample_t'(small_v - 4096);
        end else begin
          dry = srv_pkg::sample_t'($urandom);
        end
        send_sample(dry, 1'b0, '0);
        rand_sent++;
      end
      phase++;
    end
    no_idle = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (wet_expected_q.size() != 0)
      $display("%0d wet_sample results never arrived", wet_expected_q.size());
    if (fault_count == 0 && wet_expected_q.size() == 0) begin
      $display("spring_reverb_allpass_comb_core test passed");
    end else begin
      $display("spring_reverb_allpass_comb_core test failed");
    end
    $finish;
  end

endmodule
